FILE: src/tsh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sphere/torus hit test.
// No dependencies; every other file in src/ except tsh_checker.sv uses this package by scoped name.
package tsh_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  localparam int AXIS_W    = 16;
  localparam int AXIS_FRAC = 14;

  // Projected and difference vectors are clamped to +-(2^30 - 1).
  localparam int SAT_W  = 31;
  localparam int MAG_W  = SAT_W - 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D2_W   = 2 * SAT_W;
  localparam int ROOT_W = D2_W / 2;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 31'sh3FFF_FFFF;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_RADIUS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TUBE_RADIUS = 3'd7;

  localparam logic signed [AXIS_W-1:0] AXIS_X_RST = 16'sd0;
  localparam logic signed [AXIS_W-1:0] AXIS_Y_RST = 16'sd16384;
  localparam logic signed [AXIS_W-1:0] AXIS_Z_RST = 16'sd0;
  localparam int MAIN_RADIUS_RST = 4096;
  localparam int TUBE_RADIUS_RST = 819;

  // Magnitude of a clamped value; the clamp keeps -x in range.
  function automatic logic [MAG_W-1:0] sat_mag(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] m;
    m = (x < 0) ? -x : x;
    return m[MAG_W-1:0];
  endfunction

endpackage

FILE: src/torus_sphere_hit_test.sv
`timescale 1ns / 1ps
// Top level of the sphere/torus hit test: configuration registers, the
// nearest-point and compare stages, and the output buffer.
// Uses tsh_pkg, tsh_front, tsh_sqrt and tsh_div.
//
// Usage:
//   The input channel (in_valid, in_stall) takes one sphere item per cycle:
//   while not stalled: center in_sphere_x/y/z and in_sphere_radius, all
//   Q12.12. The result channel (out_valid, out_stall) returns one item per
//   sphere, out_hit, in the same order. An item moves when valid is high
//   and stall is low. The depth is set by the square root (one bit per
//   stage) and the divider (one quotient bit per stage). Throughput is one
//   item per cycle while the output buffer has room. A two-entry output
//   buffer sits behind the pipeline. The pipeline moves while the buffer
//   has room, so an item is accepted while one result waits; when both
//   entries are full the pipeline holds and in_stall rises. Reset empties
//   the pipeline and the buffer and loads the default torus (unit y axis,
//   main radius 1.0, tube radius 0.2). Registers are written through
//   cfg_we/cfg_index/cfg_wdata; the user must write them only while the
//   block is idle, as the block itself does not enforce it.
module torus_sphere_hit_test #(
  parameter int COORD_WIDTH = tsh_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_sphere_x,
  input  logic signed [COORD_WIDTH-1:0]     in_sphere_y,
  input  logic signed [COORD_WIDTH-1:0]     in_sphere_z,
  input  logic        [COORD_WIDTH-2:0]     in_sphere_radius,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  input  logic                              cfg_we,
  input  logic [tsh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int VW   = CW + 1;
  localparam int SAT  = tsh_pkg::SAT_W;
  localparam int NW   = CW + 30;
  localparam int QW   = ((CW > 31) ? CW : 31) + 2;
  localparam int WW   = QW + 2;
  localparam int MW   = CW + 29;
  localparam int SW1  = 3 * VW + 3 * SAT + CW;
  localparam int SW2  = 3 * VW + 3 + CW + 1;
  localparam int LSQW = 2 * CW;
  localparam int CMPW = (2 * CW > tsh_pkg::D2_W) ? 2 * CW : tsh_pkg::D2_W;
  localparam int RTW  = tsh_pkg::ROOT_W;

  localparam logic signed [WW-1:0] W_HI = WW'(tsh_pkg::SAT_MAX);
  localparam logic signed [WW-1:0] W_LO = -W_HI;
  localparam logic [1:0] BUF_FULL = 2'd2;

  // Configuration registers.
  logic signed [CW-1:0]              center_x_r, center_y_r, center_z_r;
  logic signed [tsh_pkg::AXIS_W-1:0] axis_x_r, axis_y_r, axis_z_r;
  logic        [CW-2:0]              main_radius_r, tube_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      center_z_r    <= '0;
      axis_x_r      <= tsh_pkg::AXIS_X_RST;
      axis_y_r      <= tsh_pkg::AXIS_Y_RST;
      axis_z_r      <= tsh_pkg::AXIS_Z_RST;
      main_radius_r <= (CW-1)'(tsh_pkg::MAIN_RADIUS_RST);
      tube_radius_r <= (CW-1)'(tsh_pkg::TUBE_RADIUS_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        tsh_pkg::REG_CENTER_X:    center_x_r    <= cfg_wdata;
        tsh_pkg::REG_CENTER_Y:    center_y_r    <= cfg_wdata;
        tsh_pkg::REG_CENTER_Z:    center_z_r    <= cfg_wdata;
        tsh_pkg::REG_AXIS_X:      axis_x_r      <= cfg_wdata[tsh_pkg::AXIS_W-1:0];
        tsh_pkg::REG_AXIS_Y:      axis_y_r      <= cfg_wdata[tsh_pkg::AXIS_W-1:0];
        tsh_pkg::REG_AXIS_Z:      axis_z_r      <= cfg_wdata[tsh_pkg::AXIS_W-1:0];
        tsh_pkg::REG_MAIN_RADIUS: main_radius_r <= cfg_wdata[CW-2:0];
        tsh_pkg::REG_TUBE_RADIUS: tube_radius_r <= cfg_wdata[CW-2:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together while the output buffer has room.
  logic [1:0] buf_cnt_r;
  logic       en;

  assign en       = (buf_cnt_r != BUF_FULL);
  assign in_stall = !en;

  // Offset, projection and squared in-plane distance.
  logic                             f_valid;
  logic [tsh_pkg::D2_W-1:0]         f_d2;
  logic signed [VW-1:0]             f_v [3];
  logic signed [SAT-1:0]            f_p [3];
  logic [CW-1:0]                    f_lim;

  tsh_front #(.CW(CW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .sphere_x      (in_sphere_x),
    .sphere_y      (in_sphere_y),
    .sphere_z      (in_sphere_z),
    .sphere_radius (in_sphere_radius),
    .center_x      (center_x_r),
    .center_y      (center_y_r),
    .center_z      (center_z_r),
    .axis_x        (axis_x_r),
    .axis_y        (axis_y_r),
    .axis_z        (axis_z_r),
    .tube_radius   (tube_radius_r),
    .valid_o       (f_valid),
    .d2_o          (f_d2),
    .v_o           (f_v),
    .p_o           (f_p),
    .lim_o         (f_lim)
  );

  // Length of the projected vector.
  logic [SW1-1:0] sq_side_in, s_side;
  logic           s_valid;
  logic [RTW-1:0] s_root;

  assign sq_side_in = {f_v[0], f_v[1], f_v[2], f_p[0], f_p[1], f_p[2], f_lim};

  tsh_sqrt #(.XW(tsh_pkg::D2_W), .SW(SW1)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (f_valid),
    .x_i     (f_d2),
    .side_i  (sq_side_in),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  logic signed [VW-1:0]  sv [3];
  logic signed [SAT-1:0] sp [3];
  logic [CW-1:0]         slim;

  for (genvar i = 0; i < 3; i++) begin : g_unpack_s
    assign sv[i] = s_side[SW1-1-i*VW -: VW];
    assign sp[i] = s_side[SW1-3*VW-1-i*SAT -: SAT];
  end
  assign slim = s_side[CW-1:0];

  // Scale |p| by the main radius.
  logic                 m_valid_r;
  logic [MW-1:0]        m_mag_r [3];
  logic [MW-1:0]        m_mag_nxt [3];
  logic [RTW-1:0]       m_d_r;
  logic signed [VW-1:0] m_v_r [3];
  logic [2:0]           m_sgn_r;
  logic [CW-1:0]        m_lim_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_mag_nxt[i] = MW'(tsh_pkg::sat_mag(sp[i])) * MW'(main_radius_r);
    end
  end

  // Add half the divisor so the quotient rounds half away from zero.
  logic                 n_valid_r;
  logic [NW-1:0]        n_num_r [3];
  logic [RTW-1:0]       n_d_r;
  logic signed [VW-1:0] n_v_r [3];
  logic [2:0]           n_sgn_r;
  logic [CW-1:0]        n_lim_r;
  logic                 n_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      n_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= s_valid;
      n_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_mag_r[i] <= m_mag_nxt[i];
        m_v_r[i]   <= sv[i];
        m_sgn_r[i] <= sp[i][SAT-1];
        n_num_r[i] <= NW'(m_mag_r[i]) + NW'(m_d_r >> 1);
      end
      m_d_r   <= s_root;
      m_lim_r <= slim;
      n_d_r   <= m_d_r;
      n_v_r   <= m_v_r;
      n_sgn_r <= m_sgn_r;
      n_lim_r <= m_lim_r;
      n_dz_r  <= (m_d_r == '0);
    end
  end

  // Nearest point on the tube circle: |p| * main_radius / |p|.
  logic [SW2-1:0] dv_side_in, d_side;
  logic           d_valid;
  logic [QW-1:0]  d_quo [3];

  assign dv_side_in = {n_v_r[0], n_v_r[1], n_v_r[2], n_sgn_r, n_lim_r, n_dz_r};

  tsh_div #(.NW(NW), .DW(RTW), .QW(QW), .SW(SW2), .LANES(3)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (n_valid_r),
    .num_i   (n_num_r),
    .den_i   (n_d_r),
    .side_i  (dv_side_in),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  logic signed [VW-1:0] dv [3];
  logic [2:0]           dsgn;
  logic [CW-1:0]        dlim;
  logic                 ddz;

  for (genvar i = 0; i < 3; i++) begin : g_unpack_d
    assign dv[i] = d_side[SW2-1-i*VW -: VW];
  end
  assign dsgn = d_side[CW+3:CW+1];
  assign dlim = d_side[CW:1];
  assign ddz  = d_side[0];

  // Difference to the nearest point; a sphere on the axis uses the center.
  // A clamped quotient is large enough that the difference still saturates.
  logic signed [WW-1:0]  q_ext [3];
  logic signed [WW-1:0]  n_val [3];
  logic signed [WW-1:0]  w_raw [3];
  logic signed [SAT-1:0] w_nxt [3];
  logic                  w_valid_r;
  logic signed [SAT-1:0] w_r [3];
  logic [CW-1:0]         w_lim_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_ext[i] = WW'(d_quo[i]);
      n_val[i] = dsgn[i] ? -q_ext[i] : q_ext[i];
      w_raw[i] = ddz ? WW'(dv[i]) : WW'(dv[i]) - n_val[i];
      if (w_raw[i] > W_HI) begin
        w_nxt[i] = tsh_pkg::SAT_MAX;
      end else if (w_raw[i] < W_LO) begin
        w_nxt[i] = -tsh_pkg::SAT_MAX;
      end else begin
        w_nxt[i] = w_raw[i][SAT-1:0];
      end
    end
  end

  // Squares, then the final sum and compare.
  logic                       sq_valid_r;
  logic [tsh_pkg::SQ_W-1:0]   sq_w_r [3];
  logic [LSQW-1:0]            sq_lim_r;
  logic                       c_valid_r;
  logic                       c_hit_r;
  logic [tsh_pkg::D2_W-1:0]   dist2;

  assign dist2 = tsh_pkg::D2_W'(sq_w_r[0]) + tsh_pkg::D2_W'(sq_w_r[1])
               + tsh_pkg::D2_W'(sq_w_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r  <= 1'b0;
      sq_valid_r <= 1'b0;
      c_valid_r  <= 1'b0;
    end else if (en) begin
      w_valid_r  <= d_valid;
      sq_valid_r <= w_valid_r;
      c_valid_r  <= sq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w_r[i]    <= w_nxt[i];
        sq_w_r[i] <= tsh_pkg::SQ_W'(tsh_pkg::sat_mag(w_r[i]))
                   * tsh_pkg::SQ_W'(tsh_pkg::sat_mag(w_r[i]));
      end
      w_lim_r  <= dlim;
      sq_lim_r <= LSQW'(w_lim_r) * LSQW'(w_lim_r);
      c_hit_r  <= CMPW'(dist2) <= CMPW'(sq_lim_r);
    end
  end

  // Two-entry output buffer.
  logic       buf_hit_r [2];
  logic       buf_wr_r, buf_rd_r;
  logic       push, pop;

  assign push = en && c_valid_r;
  assign pop  = (buf_cnt_r != '0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
      buf_wr_r  <= 1'b0;
      buf_rd_r  <= 1'b0;
    end else begin
      if (push) begin
        buf_wr_r <= !buf_wr_r;
      end
      if (pop) begin
        buf_rd_r <= !buf_rd_r;
      end
      if (push && !pop) begin
        buf_cnt_r <= buf_cnt_r + 2'd1;
      end else if (pop && !push) begin
        buf_cnt_r <= buf_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_hit_r[buf_wr_r] <= c_hit_r;
    end
  end

  assign out_valid = (buf_cnt_r != '0);
  assign out_hit   = buf_hit_r[buf_rd_r];

endmodule

FILE: src/tsh_front.sv
`timescale 1ns / 1ps
// Front end: offset from the torus center, projection onto the torus plane
// and squared in-plane distance, seven register stages. Uses tsh_pkg.
module tsh_front #(
  parameter int CW = tsh_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [CW-1:0]                sphere_x,
  input  logic signed [CW-1:0]                sphere_y,
  input  logic signed [CW-1:0]                sphere_z,
  input  logic        [CW-2:0]                sphere_radius,
  input  logic signed [CW-1:0]                center_x,
  input  logic signed [CW-1:0]                center_y,
  input  logic signed [CW-1:0]                center_z,
  input  logic signed [tsh_pkg::AXIS_W-1:0]   axis_x,
  input  logic signed [tsh_pkg::AXIS_W-1:0]   axis_y,
  input  logic signed [tsh_pkg::AXIS_W-1:0]   axis_z,
  input  logic        [CW-2:0]                tube_radius,
  output logic                                valid_o,
  output logic        [tsh_pkg::D2_W-1:0]     d2_o,
  output logic signed [CW:0]                  v_o [3],
  output logic signed [tsh_pkg::SAT_W-1:0]    p_o [3],
  output logic        [CW-1:0]                lim_o
);

  localparam int VW  = CW + 1;
  localparam int PW  = CW + 17;
  localparam int AW  = CW + 19;
  localparam int DTW = AW - tsh_pkg::AXIS_FRAC;
  localparam int TW  = CW + 21;
  localparam int TTW = TW - tsh_pkg::AXIS_FRAC;
  localparam int RW  = (CW + 8 > 32) ? CW + 8 : 32;
  localparam int NST = 7;

  localparam logic signed [AW-1:0] RND_A = AW'(1) << (tsh_pkg::AXIS_FRAC - 1);
  localparam logic signed [TW-1:0] RND_T = TW'(1) << (tsh_pkg::AXIS_FRAC - 1);
  localparam logic signed [RW-1:0] LIM_HI = RW'(tsh_pkg::SAT_MAX);
  localparam logic signed [RW-1:0] LIM_LO = -LIM_HI;

  logic signed [CW-1:0]              sph [3];
  logic signed [CW-1:0]              ctr [3];
  logic signed [tsh_pkg::AXIS_W-1:0] ax  [3];

  logic [NST-1:0]                    valid_r;
  logic signed [VW-1:0]              v_r   [NST][3];
  logic        [CW-1:0]              lim_r [NST];
  logic signed [PW-1:0]              prod_r [3];
  logic signed [DTW-1:0]             dot_r;
  logic signed [TW-1:0]              ad_r [3];
  logic signed [tsh_pkg::SAT_W-1:0]  p_r  [3][3];
  logic        [tsh_pkg::SQ_W-1:0]   sq_r [3];
  logic        [tsh_pkg::D2_W-1:0]   d2_r;

  logic signed [VW-1:0]              v_nxt [3];
  logic        [CW-1:0]              lim_nxt;
  logic signed [PW-1:0]              prod_nxt [3];
  logic signed [AW-1:0]              acc_nxt;
  logic signed [DTW-1:0]             dot_nxt;
  logic signed [TW-1:0]              ad_nxt [3];
  logic signed [TW-1:0]              t_sum [3];
  logic signed [TTW-1:0]             t_val [3];
  logic signed [RW-1:0]              p_raw [3];
  logic signed [tsh_pkg::SAT_W-1:0]  p_nxt [3];
  logic        [tsh_pkg::SQ_W-1:0]   sq_nxt [3];
  logic        [tsh_pkg::D2_W-1:0]   d2_nxt;

  assign sph[0] = sphere_x;
  assign sph[1] = sphere_y;
  assign sph[2] = sphere_z;
  assign ctr[0] = center_x;
  assign ctr[1] = center_y;
  assign ctr[2] = center_z;
  assign ax[0]  = axis_x;
  assign ax[1]  = axis_y;
  assign ax[2]  = axis_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_nxt[i]    = VW'(sph[i]) - VW'(ctr[i]);
      prod_nxt[i] = v_r[0][i] * ax[i];
      ad_nxt[i]   = ax[i] * dot_r;
      // Round half up, then drop the axis fraction.
      t_sum[i]    = ad_r[i] + RND_T;
      t_val[i]    = t_sum[i][TW-1:tsh_pkg::AXIS_FRAC];
      p_raw[i]    = RW'(v_r[3][i]) - RW'(t_val[i]);
      if (p_raw[i] > LIM_HI) begin
        p_nxt[i] = tsh_pkg::SAT_MAX;
      end else if (p_raw[i] < LIM_LO) begin
        p_nxt[i] = -tsh_pkg::SAT_MAX;
      end else begin
        p_nxt[i] = p_raw[i][tsh_pkg::SAT_W-1:0];
      end
      sq_nxt[i] = tsh_pkg::SQ_W'(tsh_pkg::sat_mag(p_r[0][i]))
                * tsh_pkg::SQ_W'(tsh_pkg::sat_mag(p_r[0][i]));
    end
    lim_nxt = CW'(sphere_radius) + CW'(tube_radius);
    acc_nxt = AW'(prod_r[0]) + AW'(prod_r[1]) + AW'(prod_r[2]) + RND_A;
    dot_nxt = acc_nxt[AW-1:tsh_pkg::AXIS_FRAC];
    d2_nxt  = tsh_pkg::D2_W'(sq_r[0]) + tsh_pkg::D2_W'(sq_r[1])
            + tsh_pkg::D2_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v_r[0][i] <= v_nxt[i];
        prod_r[i] <= prod_nxt[i];
        ad_r[i]   <= ad_nxt[i];
        p_r[0][i] <= p_nxt[i];
        p_r[1][i] <= p_r[0][i];
        p_r[2][i] <= p_r[1][i];
        sq_r[i]   <= sq_nxt[i];
      end
      for (int s = 1; s < NST; s++) begin
        v_r[s]   <= v_r[s-1];
        lim_r[s] <= lim_r[s-1];
      end
      lim_r[0] <= lim_nxt;
      dot_r    <= dot_nxt;
      d2_r     <= d2_nxt;
    end
  end

  assign valid_o = valid_r[NST-1];
  assign d2_o    = d2_r;
  assign v_o     = v_r[NST-1];
  assign p_o     = p_r[2];
  assign lim_o   = lim_r[NST-1];

endmodule

FILE: src/tsh_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage,
// with a sideband that travels alongside. Uses tsh_pkg for defaults.
module tsh_sqrt #(
  parameter int XW = tsh_pkg::D2_W,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [XW-1:0]     x_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [XW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int RTW = XW / 2;

  logic            vld_q  [RTW+1];
  logic [XW-1:0]   rem_q  [RTW+1];
  logic [RTW-1:0]  root_q [RTW+1];
  logic [SW-1:0]   side_q [RTW+1];

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = x_i;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < RTW; s++) begin : g_stage
    localparam int B = RTW - 1 - s;

    logic           vld_r;
    logic [XW-1:0]  rem_r, rem_nxt, trial;
    logic [RTW-1:0] root_r, root_nxt;
    logic [SW-1:0]  side_r;

    // Try setting bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B).
    always_comb begin
      trial = (XW'(root_q[s]) << (B + 1)) | (XW'(1) << (2 * B));
      if (rem_q[s] >= trial) begin
        rem_nxt  = rem_q[s] - trial;
        root_nxt = root_q[s] | (RTW'(1) << B);
      end else begin
        rem_nxt  = rem_q[s];
        root_nxt = root_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        side_r <= side_q[s];
      end
    end

    assign vld_q[s+1]  = vld_r;
    assign rem_q[s+1]  = rem_r;
    assign root_q[s+1] = root_r;
    assign side_q[s+1] = side_r;
  end

  assign valid_o = vld_q[RTW];
  assign root_o  = root_q[RTW];
  assign side_o  = side_q[RTW];

endmodule

FILE: src/tsh_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for several lanes sharing one divisor, one
// quotient bit per stage, quotient clamped to all ones on overflow. Uses tsh_pkg.
module tsh_div #(
  parameter int NW    = tsh_pkg::D2_W,
  parameter int DW    = tsh_pkg::ROOT_W,
  parameter int QW    = tsh_pkg::ROOT_W + 2,
  parameter int SW    = 1,
  parameter int LANES = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [NW-1:0]     num_i [LANES],
  input  logic [DW-1:0]     den_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o [LANES],
  output logic [SW-1:0]     side_o
);

  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_q  [QW+1];
  logic [NW-1:0] rem_q  [QW+1][LANES];
  logic [QW-1:0] quo_q  [QW+1][LANES];
  logic          ovf_q  [QW+1][LANES];
  logic [DW-1:0] den_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  // Entry stage: flag quotients that do not fit in QW bits.
  logic          pre_vld_r;
  logic [NW-1:0] pre_rem_r [LANES];
  logic          pre_ovf_r [LANES];
  logic          pre_ovf_nxt [LANES];
  logic [DW-1:0] pre_den_r;
  logic [SW-1:0] pre_side_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pre_ovf_nxt[l] = EW'(num_i[l]) >= (EW'(den_i) << QW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_rem_r  <= num_i;
      pre_ovf_r  <= pre_ovf_nxt;
      pre_den_r  <= den_i;
      pre_side_r <= side_i;
    end
  end

  assign vld_q[0]  = pre_vld_r;
  assign rem_q[0]  = pre_rem_r;
  assign ovf_q[0]  = pre_ovf_r;
  assign den_q[0]  = pre_den_r;
  assign side_q[0] = pre_side_r;

  for (genvar l = 0; l < LANES; l++) begin : g_quo0
    assign quo_q[0][l] = '0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;

    logic          vld_r;
    logic [NW-1:0] rem_r [LANES];
    logic [NW-1:0] rem_nxt [LANES];
    logic [QW-1:0] quo_r [LANES];
    logic [QW-1:0] quo_nxt [LANES];
    logic          ovf_r [LANES];
    logic [DW-1:0] den_r;
    logic [SW-1:0] side_r;
    logic [EW-1:0] shd;

    always_comb begin
      shd = EW'(den_q[s]) << B;
      for (int l = 0; l < LANES; l++) begin
        if (EW'(rem_q[s][l]) >= shd) begin
          rem_nxt[l] = NW'(EW'(rem_q[s][l]) - shd);
          quo_nxt[l] = quo_q[s][l] | (QW'(1) << B);
        end else begin
          rem_nxt[l] = rem_q[s][l];
          quo_nxt[l] = quo_q[s][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        ovf_r  <= ovf_q[s];
        den_r  <= den_q[s];
        side_r <= side_q[s];
      end
    end

    assign vld_q[s+1]  = vld_r;
    assign rem_q[s+1]  = rem_r;
    assign quo_q[s+1]  = quo_r;
    assign ovf_q[s+1]  = ovf_r;
    assign den_q[s+1]  = den_r;
    assign side_q[s+1] = side_r;
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = ovf_q[QW][l] ? '1 : quo_q[QW][l];
    end
  end

  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];

endmodule

FILE: src/tsh_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sphere/torus hit test and its bind statement.
// Depends only on the top level's ports.
module tsh_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its value.
  a_hit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hit))
    else $error("result changed while stalled");

  // Input is only held back when finished results are waiting.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // Reset leaves the block empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind torus_sphere_hit_test tsh_checker u_tsh_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for torus_sphere_hit_test: drives sphere items under
// several torus settings and compares each hit flag with a local predictor.
// Depends on tsh_pkg and the RTL in src/.
module tb_top;

  localparam int CW         = tsh_pkg::COORD_WIDTH_DEF;
  localparam int PIPE_DEPTH = 78;       // Settling margin used by drain and the final wait.
  localparam int LIMIT      = 400000;   // Generous cycle limit for the whole run.
  localparam longint SAT_LIM = 64'sd1073741823;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_sphere_x = '0;
  logic signed [CW-1:0] in_sphere_y = '0;
  logic signed [CW-1:0] in_sphere_z = '0;
  logic [CW-2:0] in_sphere_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic cfg_we = 1'b0;
  logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;

  torus_sphere_hit_test u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sphere_x(in_sphere_x), .in_sphere_y(in_sphere_y),
    .in_sphere_z(in_sphere_z), .in_sphere_radius(in_sphere_radius),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Local copy of the torus registers, kept in step with every write.
  logic signed [CW-1:0] torus_center [3];
  logic signed [tsh_pkg::AXIS_W-1:0] torus_axis [3];
  logic [CW-2:0] main_r;
  logic [CW-2:0] tube_r;

  bit     hit_queue [$];   // Expected hit flags, oldest first.
  int     errors = 0;
  int     items_sent = 0;
  int     results_seen = 0;
  int     hits_seen = 0;
  int     settings_used = 1;
  int     cycles = 0;
  int     stall_left = 0;
  bit     calm = 1'b0;     // When set, neither side inserts idle cycles.

  // Clamp to +-(2^30 - 1), as the block does for p and w.
  function automatic longint clamp30(input longint x);
    if (x > SAT_LIM) return SAT_LIM;
    if (x < -SAT_LIM) return -SAT_LIM;
    return x;
  endfunction

  // Add half an LSB, then floor-divide by 2^14.
  function automatic longint axis_round(input longint x);
    return (x + 64'sd8192) >>> tsh_pkg::AXIS_FRAC;
  endfunction

  function automatic longint unsigned square_mag(input longint x);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : longint'(x);
    return m * m;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Predicts the hit flag for one sphere under the current torus registers.
  function automatic bit predict_hit(input logic signed [CW-1:0] sx,
                                     input logic signed [CW-1:0] sy,
                                     input logic signed [CW-1:0] sz,
                                     input logic [CW-2:0] sr);
    longint v [3];
    longint a [3];
    longint p [3];
    longint w [3];
    longint acc, dot, q, nrm;
    longint unsigned d2, dist2, lim, root, mag;
    v[0] = longint'(sx) - longint'(torus_center[0]);
    v[1] = longint'(sy) - longint'(torus_center[1]);
    v[2] = longint'(sz) - longint'(torus_center[2]);
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(torus_axis[i]);
      acc += v[i] * a[i];
    end
    dot = axis_round(acc);
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = clamp30(v[i] - axis_round(a[i] * dot));
      d2 += square_mag(p[i]);
    end
    if (d2 == 0) begin
      // On the axis the nearest point is the torus center itself.
      for (int i = 0; i < 3; i++) w[i] = clamp30(v[i]);
    end else begin
      root = root_floor(d2);
      for (int i = 0; i < 3; i++) begin
        mag = longint'((p[i] < 0) ? -p[i] : p[i]) * longint'({1'b0, main_r});
        q = longint'((mag + root / 2) / root);
        nrm = (p[i] < 0) ? -q : q;
        w[i] = clamp30(v[i] - nrm);
      end
    end
    dist2 = 0;
    for (int i = 0; i < 3; i++) dist2 += square_mag(w[i]);
    lim = longint'({1'b0, tube_r}) + longint'({1'b0, sr});
    return dist2 <= lim * lim;
  endfunction

  // Watches both channels. Inputs change at the falling edge, so values read
  // here at the rising edge are the ones the block samples.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Run exceeded %0d cycles with %0d results pending.",
               LIMIT, hit_queue.size());
      $display("[torus_sphere_hit_test] ERROR");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      hit_queue.push_back(predict_hit(in_sphere_x, in_sphere_y, in_sphere_z,
                                      in_sphere_radius));
      items_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_hit) hits_seen++;
      if (hit_queue.size() == 0) begin
        $display("%t unexpected result item: expected none, got hit=%0d",
                 $time, out_hit);
        errors++;
      end else begin
        bit want;
        want = hit_queue.pop_front();
        if (out_hit !== want) begin
          $display("%t hit mismatch: expected %0d, got %0d", $time, want, out_hit);
          errors++;
        end
      end
      stall_left = calm ? 0 : $urandom_range(0, 4);
    end
  end

  // The receiver holds off for the number of cycles drawn for each result.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sends one sphere item. Entered and left at a falling edge; valid stays
  // high on return so back-to-back items need no extra cycle.
  task automatic send_sphere(input logic signed [CW-1:0] sx,
                             input logic signed [CW-1:0] sy,
                             input logic signed [CW-1:0] sz,
                             input logic [CW-2:0] sr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sphere_x <= sx;
    in_sphere_y <= sy;
    in_sphere_z <= sz;
    in_sphere_radius <= sr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every expected result is back, then lets the pipeline settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [tsh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tsh_pkg::REG_CENTER_X:    torus_center[0] = value;
      tsh_pkg::REG_CENTER_Y:    torus_center[1] = value;
      tsh_pkg::REG_CENTER_Z:    torus_center[2] = value;
      tsh_pkg::REG_AXIS_X:      torus_axis[0] = value[tsh_pkg::AXIS_W-1:0];
      tsh_pkg::REG_AXIS_Y:      torus_axis[1] = value[tsh_pkg::AXIS_W-1:0];
      tsh_pkg::REG_AXIS_Z:      torus_axis[2] = value[tsh_pkg::AXIS_W-1:0];
      tsh_pkg::REG_MAIN_RADIUS: main_r = value[CW-2:0];
      tsh_pkg::REG_TUBE_RADIUS: tube_r = value[CW-2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Loads a complete torus setting; the block must be idle.
  task automatic load_torus(input int cx, input int cy, input int cz,
                            input int ax, input int ay, input int az,
                            input int rm, input int rt);
    drain();
    write_reg(tsh_pkg::REG_CENTER_X, cx[CW-1:0]);
    write_reg(tsh_pkg::REG_CENTER_Y, cy[CW-1:0]);
    write_reg(tsh_pkg::REG_CENTER_Z, cz[CW-1:0]);
    write_reg(tsh_pkg::REG_AXIS_X, CW'(ax[tsh_pkg::AXIS_W-1:0]));
    write_reg(tsh_pkg::REG_AXIS_Y, CW'(ay[tsh_pkg::AXIS_W-1:0]));
    write_reg(tsh_pkg::REG_AXIS_Z, CW'(az[tsh_pkg::AXIS_W-1:0]));
    write_reg(tsh_pkg::REG_MAIN_RADIUS, CW'(rm[CW-2:0]));
    write_reg(tsh_pkg::REG_TUBE_RADIUS, CW'(rt[CW-2:0]));
    settings_used++;
  endtask

  // One random sphere. Most land near the tube so that both outcomes are
  // common; some are unconstrained, some sit on the axis line.
  task automatic send_random_sphere;
    int pick, span, k;
    logic signed [CW-1:0] c [3];
    logic [CW-2:0] rad;
    pick = $urandom_range(0, 9);
    span = int'(main_r) + int'(tube_r) + 64;
    if (span > 4_000_000) span = 4_000_000;
    rad = (CW-1)'($urandom_range(0, int'(tube_r) + 64));
    if (pick < 7) begin
      for (int i = 0; i < 3; i++)
        c[i] = torus_center[i] + CW'(int'($urandom_range(0, 2 * span)) - span);
    end else if (pick < 9) begin
      for (int i = 0; i < 3; i++) c[i] = CW'($urandom());
      rad = (CW-1)'($urandom());
    end else begin
      k = int'($urandom_range(0, 2 * span)) - span;
      for (int i = 0; i < 3; i++)
        c[i] = torus_center[i] + CW'((longint'(torus_axis[i]) * k) >>> 14);
    end
    send_sphere(c[0], c[1], c[2], rad);
  endtask

  task automatic send_random_batch(input int count);
    repeat (count) send_random_sphere();
  endtask

  // Directed spheres on the reset torus: unit y axis, ring radius 1.0, tube 0.2.
  task automatic test_reset_torus;
    send_sphere(0, 0, 0, 0);              // At the center: on the axis.
    send_sphere(0, 24'sd8192, 0, 0);      // On the axis, above the hole.
    send_sphere(0, 24'sd8192, 0, 23'd6000); // Same, with a radius that stays short of the ring.
    send_sphere(24'sd4096, 0, 0, 0);      // On the tube circle.
    send_sphere(24'sd4915, 0, 0, 0);      // Exactly at the tube surface.
    send_sphere(24'sd4916, 0, 0, 0);      // Just outside the surface.
    send_sphere(0, 0, -24'sd4915, 0);
    send_sphere(-24'sd4096, 24'sd819, 0, 0);
    send_sphere(24'sd8192, 0, 0, 23'd3277);
    send_sphere(24'sd8192, 0, 0, 23'd3276);
    send_sphere(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
    send_sphere(-24'sh800000, -24'sh800000, -24'sh800000, 0);
    send_sphere(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, 23'h7FFFFF);
    send_sphere(-24'sh800000, 24'sh7FFFFF, -24'sh800000, 23'h400000);
    send_sphere(24'sh555555, -24'sh2AAAAB, 24'sh0F0F0F, 23'h2AAAAA);
  endtask

  task automatic test_random_reset_torus;
    send_random_batch(150);
  endtask

  // Runs through torus settings, extremes among them, with random spheres.
  task automatic test_torus_settings;
    load_torus(0, 0, 0, 16384, 0, 0, 8192, 1024);
    calm = 1'b1;
    send_random_batch(80);
    calm = 1'b0;
    load_torus(1000, -2000, 300, 0, 0, -16384, 4096, 0);
    send_sphere(24'sd1000, -24'sd2000, 24'sd300, 0);   // At the center.
    send_sphere(24'sd5096, -24'sd2000, 24'sd300, 0);   // On the ring, zero tube.
    send_random_batch(80);
    load_torus(8388607, -8388608, 8388607, 0, -16384, 0, 8388607, 8388607);
    send_random_batch(80);
    // A zero axis leaves the offset unprojected.
    load_torus(-8388608, -8388608, -8388608, 0, 0, 0, 2048, 400);
    send_random_batch(80);
    // Axis outside the unit range, with a zero ring radius.
    load_torus(-12345, 6789, 0, 32767, -32768, 4660, 0, 100);
    send_random_batch(80);
    load_torus($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
               $urandom_range(0, 40000) - 20000, 11585, 0, -11585, 12000, 2000);
    send_random_batch(80);
    // Back to the reset torus.
    load_torus(0, 0, 0, 0, 16384, 0, 4096, 819);
    calm = 1'b1;
    send_random_batch(50);
    calm = 1'b0;
    send_random_batch(50);
  endtask

  initial begin
    torus_center = '{default: '0};
    torus_axis[0] = tsh_pkg::AXIS_X_RST;
    torus_axis[1] = tsh_pkg::AXIS_Y_RST;
    torus_axis[2] = tsh_pkg::AXIS_Z_RST;
    main_r = (CW-1)'(tsh_pkg::MAIN_RADIUS_RST);
    tube_r = (CW-1)'(tsh_pkg::TUBE_RADIUS_RST);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_torus();
    test_random_reset_torus();
    test_torus_settings();

    drain();
    repeat (PIPE_DEPTH) @(posedge clk);
    if (hit_queue.size() != 0) begin
      $display("%t %0d expected results never arrived", $time, hit_queue.size());
      errors++;
    end
    $display("Checked %0d spheres (%0d hits) under %0d torus settings.",
             results_seen, hits_seen, settings_used);
    $display("Sent %0d items; %0d mismatches.", items_sent, errors);
    if (errors == 0) begin
      $display("[torus_sphere_hit_test] OK");
    end else begin
      $display("[torus_sphere_hit_test] ERROR");
    end
    $finish;
  end

endmodule
